/* sv/cht_pkg.sv */
package cht_pkg;

	localparam int BUCKETS = 64;
	localparam int NODES = 256;
	localparam int PAYLOAD_BITS = 64;

	localparam int KEY_W = 31;
	localparam int CFG_W = 7;
	localparam int BKT_W = $clog2(BUCKETS);
	localparam int NODE_W = $clog2(NODES);
	localparam int LINK_W = NODE_W + 1;
	localparam int CNT_W = 9;
	localparam int REM_W = BKT_W + 1;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_POOL_FULL = 2'd3;

	// Result of the modulo unit.
	typedef struct packed {
		logic done;
		logic [BKT_W-1:0] rem;
	} mod_res_t;

endpackage

/* sv/chained_hash_table.sv */
// Hash table with separate chaining over a bucket-head memory and a node memory.
// Each request runs the serial modulo and the head lookup, then reads the chain node by node;
// an insert that takes a node adds a free-node read and a write, and a remove adds a step that
// returns the node to the pool; the unused command goes straight to the result.
// Throughput: one request at a time; the 31-step serial modulo and the node walk set it.
// Reset: asynchronous, active low; the pool and empty chains are ready at once
// through valid bits, and the bucket count returns to 64.
module chained_hash_table (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] cmd,
	input  logic [cht_pkg::KEY_W-1:0] key,
	input  logic [cht_pkg::PAYLOAD_BITS-1:0] entry_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [cht_pkg::PAYLOAD_BITS-1:0] found_data,
	output logic [cht_pkg::CNT_W-1:0] entry_count,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cht_pkg::CFG_W-1:0] bucket_count
);
	import cht_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MOD = 4'd1;
	localparam logic [3:0] S_HRD = 4'd2;
	localparam logic [3:0] S_HGET = 4'd3;
	localparam logic [3:0] S_NRD = 4'd4;
	localparam logic [3:0] S_FRD = 4'd5;
	localparam logic [3:0] S_INS = 4'd6;
	localparam logic [3:0] S_REM2 = 4'd7;
	localparam logic [3:0] S_RES = 4'd8;

	logic [3:0] state_q, state_d;
	logic [CFG_W-1:0] cfg_q;
	logic [CFG_W-1:0] eff_buckets;
	logic [1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [PAYLOAD_BITS-1:0] data_q;
	logic [BKT_W-1:0] bkt_q;
	logic [LINK_W-1:0] head_q, cur_q, prev_q, free_q;
	logic [CNT_W-1:0] steps_q, count_q;
	logic [1:0] st_q;
	logic [PAYLOAD_BITS-1:0] found_q;
	logic out_valid_q;
	logic [1:0] out_status_q;
	logic [PAYLOAD_BITS-1:0] out_found_q;
	logic [CNT_W-1:0] out_count_q;
	logic in_fire, div_start;
	mod_res_t mres;

	// Bucket-head memory with valid bits for the empty-chain reset.
	logic [LINK_W-1:0] bh_mem [BUCKETS];
	logic [BUCKETS-1:0] bh_v_q;
	logic [LINK_W-1:0] bh_raw_s1;
	logic bh_rv_s1;
	logic [LINK_W-1:0] bh_head;
	logic bh_we;
	logic [LINK_W-1:0] bh_wd;

	// Node memory: key, payload and link, read together at one address.
	logic [KEY_W-1:0] key_mem [NODES];
	logic [PAYLOAD_BITS-1:0] pay_mem [NODES];
	logic [LINK_W-1:0] link_mem [NODES];
	logic [NODES-1:0] lk_v_q;
	logic nd_rd_en, nd_we, lk_we;
	logic [NODE_W-1:0] nd_ra, nd_wa, lk_wa;
	logic [LINK_W-1:0] lk_wd;
	logic [KEY_W-1:0] rd_key_s1;
	logic [PAYLOAD_BITS-1:0] rd_pay_s1;
	logic [LINK_W-1:0] rd_lraw_s1, rd_link;
	logic rd_lv_s1;
	logic [NODE_W-1:0] rd_addr_s1;
	logic match, walk_end;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign div_start = in_fire && (cmd != CMD_NONE);

	// Zero buckets act as one, counts above the table size saturate.
	always_comb begin
		eff_buckets = cfg_q;
		if (cfg_q == '0)
			eff_buckets = CFG_W'(1);
		else if (cfg_q > CFG_W'(BUCKETS))
			eff_buckets = CFG_W'(BUCKETS);
	end

	cht_mod u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(key),
		.divisor(eff_buckets),
		.res(mres)
	);

	assign bh_head = bh_rv_s1 ? bh_raw_s1 : NULL_LINK;
	assign rd_link = rd_lv_s1 ? rd_lraw_s1 : LINK_W'({1'b0, rd_addr_s1} + 1'b1);
	assign match = (rd_key_s1 == key_q);
	assign walk_end = (rd_link == NULL_LINK) || (steps_q + 1'b1 == CNT_W'(NODES));

	// Sequencer and memory access control.
	always_comb begin
		state_d = state_q;
		nd_rd_en = 1'b0;
		nd_ra = cur_q[NODE_W-1:0];
		nd_we = 1'b0;
		nd_wa = free_q[NODE_W-1:0];
		lk_we = 1'b0;
		lk_wa = free_q[NODE_W-1:0];
		lk_wd = head_q;
		bh_we = 1'b0;
		bh_wd = free_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire)
					state_d = (cmd == CMD_NONE) ? S_RES : S_MOD;
			end
			S_MOD: begin
				if (mres.done)
					state_d = S_HRD;
			end
			S_HRD: state_d = S_HGET;
			S_HGET: begin
				if (bh_head == NULL_LINK) begin
					if (cmd_q == CMD_INSERT && free_q != NULL_LINK)
						state_d = S_FRD;
					else
						state_d = S_RES;
				end else begin
					nd_rd_en = 1'b1;
					nd_ra = bh_head[NODE_W-1:0];
					state_d = S_NRD;
				end
			end
			S_NRD: begin
				if (match) begin
					if (cmd_q == CMD_REMOVE) begin
						if (prev_q == NULL_LINK) begin
							bh_we = 1'b1;
							bh_wd = rd_link;
						end else begin
							lk_we = 1'b1;
							lk_wa = prev_q[NODE_W-1:0];
							lk_wd = rd_link;
						end
						state_d = S_REM2;
					end else begin
						state_d = S_RES;
					end
				end else if (walk_end) begin
					if (cmd_q == CMD_INSERT && free_q != NULL_LINK)
						state_d = S_FRD;
					else
						state_d = S_RES;
				end else begin
					nd_rd_en = 1'b1;
					nd_ra = rd_link[NODE_W-1:0];
				end
			end
			S_FRD: begin
				nd_rd_en = 1'b1;
				nd_ra = free_q[NODE_W-1:0];
				state_d = S_INS;
			end
			S_INS: begin
				nd_we = 1'b1;
				lk_we = 1'b1;
				bh_we = 1'b1;
				state_d = S_RES;
			end
			S_REM2: begin
				lk_we = 1'b1;
				lk_wa = cur_q[NODE_W-1:0];
				lk_wd = free_q;
				state_d = S_RES;
			end
			S_RES: begin
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q <= CFG_W'(BUCKETS);
			free_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			bh_v_q <= '0;
			lk_v_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				cfg_q <= bucket_count;
			if (bh_we)
				bh_v_q[bkt_q] <= 1'b1;
			if (lk_we)
				lk_v_q[lk_wa] <= 1'b1;
			if (state_q == S_INS) begin
				free_q <= rd_link;
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_REM2) begin
				free_q <= cur_q;
				if (count_q != '0)
					count_q <= count_q - 1'b1;
			end
			if (state_q == S_RES && state_d == S_IDLE)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Request context and result registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd;
			key_q <= key;
			data_q <= entry_data;
			st_q <= ST_OK;
			found_q <= '0;
		end
		if (state_q == S_MOD && mres.done)
			bkt_q <= mres.rem;
		if (state_q == S_HGET) begin
			head_q <= bh_head;
			cur_q <= bh_head;
			prev_q <= NULL_LINK;
			steps_q <= '0;
			if (bh_head == NULL_LINK)
				st_q <= (cmd_q != CMD_INSERT) ? ST_NOT_FOUND :
					(free_q == NULL_LINK) ? ST_POOL_FULL : ST_OK;
		end
		if (state_q == S_NRD) begin
			if (match) begin
				if (cmd_q == CMD_INSERT)
					st_q <= ST_DUPLICATE;
				else if (cmd_q == CMD_SEARCH)
					found_q <= rd_pay_s1;
			end else if (walk_end) begin
				st_q <= (cmd_q != CMD_INSERT) ? ST_NOT_FOUND :
					(free_q == NULL_LINK) ? ST_POOL_FULL : ST_OK;
			end else begin
				prev_q <= cur_q;
				cur_q <= rd_link;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (state_q == S_RES && state_d == S_IDLE) begin
			out_status_q <= st_q;
			out_found_q <= found_q;
			out_count_q <= count_q;
		end
	end

	// Bucket-head memory.
	always_ff @(posedge clk) begin
		if (bh_we)
			bh_mem[bkt_q] <= bh_wd;
		if (state_q == S_HRD) begin
			bh_raw_s1 <= bh_mem[bkt_q];
			bh_rv_s1 <= bh_v_q[bkt_q];
		end
	end

	// Node memory.
	always_ff @(posedge clk) begin
		if (nd_we) begin
			key_mem[nd_wa] <= key_q;
			pay_mem[nd_wa] <= data_q;
		end
		if (lk_we)
			link_mem[lk_wa] <= lk_wd;
		if (nd_rd_en) begin
			rd_key_s1 <= key_mem[nd_ra];
			rd_pay_s1 <= pay_mem[nd_ra];
			rd_lraw_s1 <= link_mem[nd_ra];
			rd_lv_s1 <= lk_v_q[nd_ra];
			rd_addr_s1 <= nd_ra;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign found_data = out_found_q;
	assign entry_count = out_count_q;

	// The pool is empty exactly when every node holds an entry.
	a_pool_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q == NULL_LINK) == (count_q == CNT_W'(NODES)))
		else $error("free pool and entry count disagree");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NODES))
		else $error("entry count beyond pool size");

	// The modulo unit finishes only while the sequencer waits for it.
	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mres.done |-> state_q == S_MOD)
		else $error("modulo result outside its wait state");

	// A request is taken only when no earlier one is in flight.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_MOD || state_q == S_RES)
		else $error("request accepted into a wrong state");

endmodule

/* sv/cht_mod.sv */
module cht_mod (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [cht_pkg::KEY_W-1:0] dividend,
	input  logic [cht_pkg::CFG_W-1:0] divisor,
	output cht_pkg::mod_res_t res
);
	import cht_pkg::*;

	localparam int CNT_BITS = $clog2(KEY_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [KEY_W-1:0] shr_q;
	logic [REM_W-1:0] rem_q;
	logic [CFG_W-1:0] div_q;
	logic [REM_W:0] trial;

	// One restoring step: shift in the next dividend bit and subtract if it fits.
	assign trial = {rem_q, shr_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shr_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			shr_q <= {shr_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q})
				rem_q <= REM_W'(trial - {1'b0, div_q});
			else
				rem_q <= REM_W'(trial);
		end
	end

	assign res.done = done_q;
	assign res.rem = rem_q[BKT_W-1:0];

endmodule

/* tb/sv/tb_chained_hash_table.sv */
module tb_chained_hash_table;
	import cht_pkg::*;

	typedef struct {
		logic [1:0] status;
		logic [PAYLOAD_BITS-1:0] data;
		logic [CNT_W-1:0] count;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_INSERT;
	logic [KEY_W-1:0] key = '0;
	logic [PAYLOAD_BITS-1:0] entry_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [PAYLOAD_BITS-1:0] found_data;
	logic [CNT_W-1:0] entry_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] bucket_count = CFG_W'(BUCKETS);

	// Local copy of the table used for prediction.
	logic [LINK_W-1:0] mdl_head [BUCKETS];
	logic [KEY_W-1:0] mdl_key [NODES];
	logic [PAYLOAD_BITS-1:0] mdl_payload [NODES];
	logic [LINK_W-1:0] mdl_link [NODES];
	logic [LINK_W-1:0] mdl_free;
	logic [CNT_W-1:0] mdl_count;
	logic [CFG_W-1:0] mdl_buckets;

	lookup_result_t pending_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [KEY_W-1:0] key_base = '0;

	chained_hash_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.key(key),
		.entry_data(entry_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_data(found_data),
		.entry_count(entry_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.bucket_count(bucket_count)
	);

	always #10 clk = ~clk;

	// Walks a chain and returns the matching node or null, with its predecessor.
	function automatic logic [LINK_W-1:0] find_entry(int b, logic [KEY_W-1:0] k,
			output logic [LINK_W-1:0] prev);
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		p = NULL_LINK;
		n = mdl_head[b];
		prev = NULL_LINK;
		for (int s = 0; s < NODES && n < NULL_LINK; s++) begin
			if (mdl_key[n] == k) begin
				prev = p;
				return n;
			end
			p = n;
			n = mdl_link[n];
		end
		return NULL_LINK;
	endfunction

	// Applies one request to the local table and returns the expected result.
	function automatic lookup_result_t apply_request(logic [1:0] c, logic [KEY_W-1:0] k,
			logic [PAYLOAD_BITS-1:0] d);
		lookup_result_t r;
		int nb;
		int b;
		logic [LINK_W-1:0] n;
		logic [LINK_W-1:0] prev;
		nb = (mdl_buckets == 0) ? 1 : ((mdl_buckets > BUCKETS) ? BUCKETS : mdl_buckets);
		b = k % nb;
		r.status = ST_OK;
		r.data = '0;
		if (c == CMD_INSERT) begin
			n = find_entry(b, k, prev);
			if (n < NULL_LINK) begin
				r.status = ST_DUPLICATE;
			end else if (mdl_free >= NULL_LINK) begin
				r.status = ST_POOL_FULL;
			end else begin
				n = mdl_free;
				mdl_free = mdl_link[n];
				mdl_key[n] = k;
				mdl_payload[n] = d;
				mdl_link[n] = mdl_head[b];
				mdl_head[b] = n;
				mdl_count++;
			end
		end else if (c == CMD_SEARCH) begin
			n = find_entry(b, k, prev);
			if (n < NULL_LINK) r.data = mdl_payload[n];
			else r.status = ST_NOT_FOUND;
		end else if (c == CMD_REMOVE) begin
			n = find_entry(b, k, prev);
			if (n < NULL_LINK) begin
				if (prev < NULL_LINK) mdl_link[prev] = mdl_link[n];
				else mdl_head[b] = mdl_link[n];
				mdl_link[n] = mdl_free;
				mdl_free = n;
				if (mdl_count > 0) mdl_count--;
			end else begin
				r.status = ST_NOT_FOUND;
			end
		end
		r.count = mdl_count;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// Sends one request transaction, sometimes after a random idle gap.
	task automatic send_request(logic [1:0] c, logic [KEY_W-1:0] k,
			logic [PAYLOAD_BITS-1:0] d);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		entry_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(apply_request(c, k, d));
	endtask

	// Waits for the table to drain, then writes the bucket count.
	task automatic set_buckets(logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		bucket_count <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mdl_buckets = v;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
		return key_base + KEY_W'($urandom_range(0, 47));
	endfunction

	function automatic logic [PAYLOAD_BITS-1:0] pick_data();
		return {$urandom, $urandom};
	endfunction

	// Receiver: random stalls, and every result transaction checked in order.
	always @(posedge clk) begin
		lookup_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(status), 64'hx);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) report_mismatch("status", 64'(status), 64'(want.status));
				if (found_data !== want.data) report_mismatch("found_data", found_data, want.data);
				if (entry_count !== want.count)
					report_mismatch("entry_count", 64'(entry_count), 64'(want.count));
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Extremes of every field, every command, head and inner removes.
	task automatic test_directed();
		set_buckets(CFG_W'(1));
		send_request(CMD_INSERT, '0, '0);
		send_request(CMD_INSERT, '1, '1);
		send_request(CMD_INSERT, KEY_W'(5), 64'h0123_4567_89ab_cdef);
		send_request(CMD_INSERT, KEY_W'(5), '1);
		send_request(CMD_SEARCH, '1, '0);
		send_request(CMD_SEARCH, '0, '1);
		send_request(CMD_SEARCH, KEY_W'(7), '0);
		send_request(CMD_NONE, KEY_W'(5), '1);
		// Remove from the middle, then from the head, then a missing key.
		send_request(CMD_REMOVE, '1, '0);
		send_request(CMD_REMOVE, KEY_W'(5), '0);
		send_request(CMD_REMOVE, KEY_W'(5), '0);
		send_request(CMD_SEARCH, '0, '0);
		// Entries stay where they were when the bucket count changes.
		set_buckets(CFG_W'(BUCKETS));
		send_request(CMD_INSERT, KEY_W'(65), 64'h5555);
		set_buckets(CFG_W'(0));
		send_request(CMD_SEARCH, KEY_W'(65), '0);
		send_request(CMD_INSERT, KEY_W'(65), 64'haaaa);
		send_request(CMD_SEARCH, KEY_W'(65), '0);
		set_buckets(CFG_W'(127));
		send_request(CMD_SEARCH, KEY_W'(65), '0);
		send_request(CMD_REMOVE, KEY_W'(65), '0);
		set_buckets(CFG_W'(1));
		send_request(CMD_REMOVE, KEY_W'(65), '0);
		send_request(CMD_REMOVE, '0, '0);
	endtask

	// Fills the pool, overflows it once, then empties it.
	task automatic test_pool_full();
		set_buckets(CFG_W'(BUCKETS));
		for (int i = 0; i <= NODES; i++) send_request(CMD_INSERT, KEY_W'(i * 3), pick_data());
		send_request(CMD_SEARCH, KEY_W'(3 * (NODES - 1)), '0);
		for (int i = 0; i < NODES; i++) send_request(CMD_REMOVE, KEY_W'(i * 3), '0);
	endtask

	// Random requests over a small key set so that hits and chains are common.
	task automatic test_random(int idle, int stall, logic [CFG_W-1:0] nb, int n);
		int r;
		logic [1:0] c;
		set_buckets(nb);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		key_base = KEY_W'($urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			c = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_SEARCH : (r < 95) ? CMD_REMOVE : CMD_NONE;
			send_request(c, pick_key(), pick_data());
		end
	endtask

	initial begin
		for (int i = 0; i < BUCKETS; i++) mdl_head[i] = NULL_LINK;
		for (int i = 0; i < NODES; i++) begin
			mdl_key[i] = '0;
			mdl_payload[i] = '0;
			mdl_link[i] = LINK_W'(i + 1);
		end
		mdl_free = '0;
		mdl_count = '0;
		mdl_buckets = CFG_W'(BUCKETS);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_full();
		test_random(0, 0, CFG_W'(BUCKETS), 250);
		test_random(65, 0, CFG_W'(7), 250);
		test_random(0, 65, CFG_W'(1), 250);
		test_random(27, 27, CFG_W'($urandom_range(2, 63)), 250);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#200000000;
		$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
sv/cht_pkg.sv
sv/cht_mod.sv
sv/chained_hash_table.sv
tb/sv/tb_chained_hash_table.sv
